### rtl/scta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scta_pkg
// Shared codes, field widths and types for the sorted cue table search unit.
// ----------------------------------------------------------------------------
package scta_pkg;

	// Field widths of the stream payloads
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned EIDX_W   = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CIDX_W   = 11;
	localparam int unsigned CCNT_W   = 11;

	// Operation codes carried on the input tuser
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ   = 2'd3;

	// Result status codes carried on the output tuser
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOCUE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic [CIDX_W-1:0]  CIDX_NONE = '1;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

	// Flags from one step of the bound search unit
	typedef struct packed {
		logic more;   // search window still open after this step
		logic hit;    // compared entry is at or below the key
	} bnd_flags_t;

endpackage
`default_nettype wire

### rtl/scta_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scta_ram
// Stamp table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scta_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/scta_bound.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scta_bound
// One step of the upper-bound search: compare the fetched entry with the key,
// narrow the window and form the next probe address.
// ----------------------------------------------------------------------------
module scta_bound #(
	parameter int unsigned CW = 11,
	parameter int unsigned AW = 10
) (
	input  wire logic                        cmp_en,
	input  wire logic [scta_pkg::STAMP_W-1:0] key,
	input  wire logic [scta_pkg::STAMP_W-1:0] rdata,
	input  wire logic [CW-1:0]               lo,
	input  wire logic [CW-1:0]               hi,
	input  wire logic [AW-1:0]               mid,
	output logic      [CW-1:0]               lo_nx,
	output logic      [CW-1:0]               hi_nx,
	output logic      [AW-1:0]               mid_nx,
	output scta_pkg::bnd_flags_t             flags
);
	import scta_pkg::*;

	logic          hit;
	logic [CW-1:0] span;
	logic [CW-1:0] mid_w;

	// Compare the fetched entry and move one side of the window
	always_comb begin
		hit   = cmp_en && (rdata <= key);
		lo_nx = lo;
		hi_nx = hi;
		if (cmp_en) begin
			if (hit) begin
				lo_nx = CW'(mid) + CW'(1);
			end else begin
				hi_nx = CW'(mid);
			end
		end
	end

	// Next probe sits halfway into the window
	assign span   = hi_nx - lo_nx;
	assign mid_w  = lo_nx + (span >> 1);
	assign mid_nx = mid_w[AW-1:0];

	assign flags.more = (lo_nx < hi_nx);
	assign flags.hit  = hit;

endmodule
`default_nettype wire

### rtl/sorted_cue_table_active_search_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_cue_table_active_search_unit
// Sorted table of cue stamps with clear, append (offset, clamp, stable insert),
// active-cue query by upper-bound binary search and indexed read.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op; tdata: time_ms, entry_index
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: index, stamp, count
//  cfg       in   cfg_wr_en                    cfg_wr_data: offset_ms
//
//  Items are worked one at a time. A query runs the bound search; an append
//  offsets and clamps the stamp, searches, moves each entry above the insert
//  position up one slot and then writes the new stamp. The single-port table
//  read and the one shared search step set this order.
//  Reset clears the entry count, the offset and the handshake state; the table
//  contents are left as they are and only entries below the count are read.
//  Input is taken only when the sequencer is idle; a finished result waits in
//  the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module sorted_cue_table_active_search_unit #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// cfg_wr_data: offset_ms[31:0]
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// s_axis_tdata: time_ms[31:0], entry_index[41:32], zero[47:42]
	input  wire logic [47:0] s_axis_tdata,
	// s_axis_tuser: op[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// m_axis_tdata: cue_index[10:0], cue_stamp[42:11], cue_count[53:43], zero[55:54]
	output logic [55:0]      m_axis_tdata,
	// m_axis_tuser: status[1:0]
	output logic [1:0]       m_axis_tuser
);
	import scta_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// Sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_OFFS  = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_SHRD  = 4'd4;
	localparam logic [3:0] S_SHWR  = 4'd5;
	localparam logic [3:0] S_INS   = 4'd6;
	localparam logic [3:0] S_RDISS = 4'd7;
	localparam logic [3:0] S_RDWT  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [STAMP_W-1:0]  key_q;
	logic [EIDX_W-1:0]   idx_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [AW-1:0]       mid_q;
	logic [CW-1:0]       k_q;
	logic [STAMP_W-1:0]  hit_stamp_q;
	logic [CW-1:0]       count_q;
	logic [STAMP_W-1:0]  offset_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [CIDX_W-1:0]   res_index_q;
	logic [STAMP_W-1:0]  res_stamp_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CIDX_W-1:0]   out_index_q;
	logic [STAMP_W-1:0]  out_stamp_q;
	logic [CCNT_W-1:0]   out_count_q;

	logic                in_fire;
	logic                out_load;
	logic [OP_W-1:0]     in_op;
	logic [STAMP_W-1:0]  in_time;
	logic [EIDX_W-1:0]   in_idx;
	logic                idx_in_range;
	logic                cmp_en;
	logic [CW-1:0]       lo_nx;
	logic [CW-1:0]       hi_nx;
	logic [AW-1:0]       mid_nx;
	bnd_flags_t          bflags;
	logic [STAMP_W-1:0]  rd_data;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [STAMP_W-1:0]  wr_data;
	logic [CW-1:0]       k_m1;
	logic [33:0]         sum;
	logic [STAMP_W-1:0]  clamped;
	logic [31:0]         pos_ext;
	logic [31:0]         posm1_ext;
	logic [31:0]         cnt_ext;
	logic [31:0]         lo_ext;
	logic [STAMP_W-1:0]  found_stamp;

	// Unpack the input transaction
	assign in_op   = s_axis_tuser;
	assign in_time = s_axis_tdata[31:0];
	assign in_idx  = s_axis_tdata[41:32];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	assign idx_in_range = (32'(in_idx) < 32'(count_q));

	// Offset the append stamp at full precision and clamp to the stamp range
	assign sum = {2'b00, key_q} + {{2{offset_q[31]}}, offset_q};
	always_comb begin
		if (sum[33]) begin
			clamped = '0;
		end else if (sum[32]) begin
			clamped = STAMP_MAX;
		end else begin
			clamped = sum[31:0];
		end
	end

	// Shared search step
	assign cmp_en = (state_q == S_CMP);

	scta_bound #(
		.CW (CW),
		.AW (AW)
	) u_bound (
		.cmp_en (cmp_en),
		.key    (key_q),
		.rdata  (rd_data),
		.lo     (lo_q),
		.hi     (hi_q),
		.mid    (mid_q),
		.lo_nx  (lo_nx),
		.hi_nx  (hi_nx),
		.mid_nx (mid_nx),
		.flags  (bflags)
	);

	assign lo_ext      = 32'(lo_nx);
	assign pos_ext     = 32'(lo_q);
	assign posm1_ext   = lo_ext - 32'd1;
	assign cnt_ext     = 32'(count_q);
	assign found_stamp = bflags.hit ? rd_data : hit_stamp_q;
	assign k_m1        = k_q - CW'(1);

	// Table address selection
	always_comb begin
		rd_addr = mid_nx;
		wr_en   = 1'b0;
		wr_addr = k_q[AW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_SHRD:  rd_addr = k_m1[AW-1:0];
			S_RDISS: rd_addr = AW'(idx_q);
			S_SHWR: begin
				wr_en = 1'b1;
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[AW-1:0];
				wr_data = key_q;
			end
			default: rd_addr = mid_nx;
		endcase
	end

	scta_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.DW    (STAMP_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold the offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// Sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (in_op)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							OP_APPEND: state_q <= (count_q == DEPTH_C) ? S_DONE : S_OFFS;
							OP_QUERY:  state_q <= S_SRCH;
							OP_READ:   state_q <= idx_in_range ? S_RDISS : S_DONE;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_OFFS: state_q <= S_SRCH;
				S_SRCH, S_CMP: begin
					if (!bflags.more) begin
						if (op_q == OP_APPEND) begin
							state_q <= (count_q > lo_nx) ? S_SHRD : S_INS;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: state_q <= (k_m1 > lo_q) ? S_SHRD : S_INS;
				S_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_RDISS: state_q <= S_RDWT;
				S_RDWT:  state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q        <= in_op;
				key_q       <= in_time;
				idx_q       <= in_idx;
				lo_q        <= '0;
				hi_q        <= count_q;
				hit_stamp_q <= '0;
				res_status_q <= ST_OK;
				res_index_q  <= '0;
				res_stamp_q  <= '0;
				if (in_op == OP_APPEND && count_q == DEPTH_C) begin
					res_status_q <= ST_FULL;
					res_index_q  <= CIDX_NONE;
				end else if (in_op == OP_READ) begin
					res_index_q <= CIDX_W'(in_idx);
					if (!idx_in_range) begin
						res_status_q <= ST_NOCUE;
					end
				end
			end
			S_OFFS: key_q <= clamped;
			S_SRCH, S_CMP: begin
				lo_q  <= lo_nx;
				hi_q  <= hi_nx;
				mid_q <= mid_nx;
				k_q   <= count_q;
				if (bflags.hit) begin
					hit_stamp_q <= rd_data;
				end
				// Query ends here: last entry at or below the key, if any
				if (!bflags.more && op_q == OP_QUERY) begin
					if (lo_nx == '0) begin
						res_status_q <= ST_NOCUE;
						res_index_q  <= CIDX_NONE;
						res_stamp_q  <= '0;
					end else begin
						res_status_q <= ST_OK;
						res_index_q  <= posm1_ext[CIDX_W-1:0];
						res_stamp_q  <= found_stamp;
					end
				end
			end
			S_SHWR: k_q <= k_m1;
			S_INS: begin
				res_status_q <= ST_OK;
				res_index_q  <= pos_ext[CIDX_W-1:0];
				res_stamp_q  <= key_q;
			end
			S_RDWT: res_stamp_q <= rd_data;
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_stamp_q  <= res_stamp_q;
			out_count_q  <= cnt_ext[CCNT_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {2'b00, out_count_q, out_stamp_q, out_index_q};

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (lo_q < hi_q))
		else $error("search window empty while comparing");

	a_shift_above_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHWR) |-> (k_q > lo_q) && (k_q <= count_q))
		else $error("shift outside insertion range");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status_q == ST_FULL) |-> (count_q == DEPTH_C))
		else $error("full status with room left");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the count");

endmodule
`default_nettype wire

### dv/sorted_cue_table_active_search_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_cue_table_active_search_unit_tb
// Self-checking bench for the cue table search unit. A scoreboard keeps its
// own sorted copy of the table and the offset, works out the result of every
// accepted input transaction and checks the output stream against it. The
// input side runs in bursts, the output side stalls on a changing pattern.
// Directed items come first, then a full-table fill and random mixed phases
// under several offset settings.
// ----------------------------------------------------------------------------
module sorted_cue_table_active_search_unit_tb;
	import scta_pkg::*;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CIDX_W-1:0]   index;
		logic [STAMP_W-1:0]  stamp;
		logic [CCNT_W-1:0]   count;
	} cue_result_t;

	// Shadow of the cue table; predicts one result per input transaction
	class cue_result_checker;
		logic [STAMP_W-1:0] stamps [TABLE_DEPTH];
		int unsigned        held;
		logic [31:0]        offset = '0;
		cue_result_t        due [$];
		int unsigned        faults;

		// Number of entries at or below key
		function int unsigned bound_after(logic [STAMP_W-1:0] key);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = held;
			while (lo < hi) begin
				mid = lo + ((hi - lo) >> 1);
				if (stamps[mid] <= key) lo = mid + 1;
				else hi = mid;
			end
			return lo;
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [STAMP_W-1:0] t,
				logic [EIDX_W-1:0] idx);
			cue_result_t        r;
			int unsigned        pos;
			int unsigned        k;
			longint             sum;
			logic [STAMP_W-1:0] v;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_CLEAR: begin
					held = 0;
				end
				OP_APPEND: begin
					if (held >= TABLE_DEPTH) begin
						r.status = ST_FULL;
						r.index = CIDX_NONE;
					end else begin
						// shift at full precision, then clamp to the stamp range
						sum = longint'(t) + longint'($signed(offset));
						if (sum < 0) v = '0;
						else if (sum > longint'(STAMP_MAX)) v = STAMP_MAX;
						else v = sum[31:0];
						// insert after equal entries
						pos = bound_after(v);
						for (k = held; k > pos; k--) stamps[k] = stamps[k - 1];
						stamps[pos] = v;
						held++;
						r.index = CIDX_W'(pos);
						r.stamp = v;
					end
				end
				OP_QUERY: begin
					if (held == 0 || t < stamps[0]) begin
						r.status = ST_NOCUE;
						r.index = CIDX_NONE;
					end else begin
						pos = bound_after(t) - 1;
						r.index = CIDX_W'(pos);
						r.stamp = stamps[pos];
					end
				end
				default: begin
					r.index = {1'b0, idx};
					if (idx < held) r.stamp = stamps[idx];
					else r.status = ST_NOCUE;
				end
			endcase
			r.count = CCNT_W'(held);
			due.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				faults++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] user, logic [55:0] data);
			cue_result_t want;
			if (due.size() == 0) begin
				$error("result transaction with nothing outstanding");
				faults++;
				return;
			end
			want = due.pop_front();
			compare("status", want.status, user);
			compare("cue_index", want.index, data[10:0]);
			compare("cue_stamp", want.stamp, data[42:11]);
			compare("cue_count", want.count, data[53:43]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // time_ms[31:0], entry_index[41:32], zero[47:42]
	logic [1:0]  s_axis_tuser;   // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;   // cue_index[10:0], cue_stamp[42:11], cue_count[53:43]
	logic [1:0]  m_axis_tuser;   // status[1:0]

	cue_result_checker sb = new();
	int unsigned       burst_left = 0;
	int unsigned       results_seen = 0;
	int unsigned       hold_left = 0;
	int unsigned       ready_mode = 0;
	int unsigned       mode_left = 0;
	int unsigned       idle_cycles = 0;

	sorted_cue_table_active_search_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one item; most bursts start after a random gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] t,
			input logic [EIDX_W-1:0] idx);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, idx, t};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(op, t, idx);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_offset(input logic [31:0] shift);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= shift;
		@(posedge clk);
		sb.offset = shift;
		cfg_wr_en <= 1'b0;
	endtask

	// Query position: mostly next to a held stamp, sometimes anywhere
	function automatic logic [STAMP_W-1:0] query_point(logic [31:0] base, logic [31:0] span);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom();
		if (r == 1) return $urandom_range(0, 1) ? STAMP_MAX : '0;
		if (sb.held == 0 || r == 2) return base + $urandom_range(0, span);
		return sb.stamps[$urandom_range(0, sb.held - 1)] + $urandom_range(0, 2) - 1;
	endfunction

	// One random phase on a small table under a given offset
	task automatic run_mix(input int unsigned n_items, input logic [31:0] shift);
		logic [31:0]     base;
		logic [31:0]     span;
		logic [31:0]     t;
		int unsigned     cap;
		int unsigned     r;
		logic [OP_W-1:0] op;
		settle();
		write_offset(shift);
		base = $urandom();
		r = $urandom_range(0, 2);
		span = (r == 0) ? 32'd16 : (r == 1) ? 32'd4000 : 32'h0100_0000;
		cap = $urandom_range(6, 60);
		send_item(OP_CLEAR, $urandom(), EIDX_W'($urandom()));
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < 3) op = OP_CLEAR;
			else if (r < 50 && sb.held < cap) op = OP_APPEND;
			else if (r < 78) op = OP_QUERY;
			else op = OP_READ;
			case (op)
				OP_APPEND: begin
					r = $urandom_range(0, 11);
					if (r == 0) t = $urandom();
					else if (r == 1) t = $urandom_range(0, 1) ? STAMP_MAX : '0;
					else t = base + $urandom_range(0, span);
					send_item(op, t, EIDX_W'($urandom()));
				end
				OP_QUERY: send_item(op, query_point(base, span), EIDX_W'($urandom()));
				OP_READ: send_item(op, $urandom(), EIDX_W'(($urandom_range(0, 4) == 0) ?
					$urandom() : $urandom_range(0, sb.held + 1)));
				default: send_item(op, $urandom(), EIDX_W'($urandom()));
			endcase
		end
	endtask

	initial begin
		logic [31:0] first;
		logic [31:0] t;
		int unsigned r;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_CLEAR;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, equal stamps, before-first and extreme positions
		send_item(OP_QUERY, '0, '0);
		send_item(OP_READ, '0, '0);
		send_item(OP_READ, STAMP_MAX, 10'h3FF);
		send_item(OP_APPEND, 32'd100, '0);
		send_item(OP_APPEND, 32'd100, '0);
		send_item(OP_APPEND, 32'd50, '0);
		send_item(OP_QUERY, 32'd49, '0);
		send_item(OP_QUERY, 32'd100, '0);
		send_item(OP_APPEND, '0, '0);
		send_item(OP_APPEND, STAMP_MAX, '0);
		send_item(OP_QUERY, '0, '0);
		send_item(OP_QUERY, STAMP_MAX, '0);
		send_item(OP_READ, '0, 10'd5);
		send_item(OP_READ, '0, 10'd6);
		send_item(OP_CLEAR, STAMP_MAX, 10'h3FF);
		send_item(OP_QUERY, STAMP_MAX, '0);

		// Most negative offset: clamp at zero
		settle();
		write_offset(32'h8000_0000);
		send_item(OP_APPEND, 32'd5, '0);
		send_item(OP_APPEND, STAMP_MAX, '0);
		send_item(OP_APPEND, 32'h8000_0000, '0);
		send_item(OP_QUERY, '0, '0);

		// Most positive offset: saturate at the stamp maximum
		settle();
		write_offset(32'h7FFF_FFFF);
		send_item(OP_APPEND, STAMP_MAX, '0);
		send_item(OP_APPEND, 32'd1, '0);
		send_item(OP_APPEND, '0, '0);
		send_item(OP_READ, '0, 10'd4);
		send_item(OP_QUERY, 32'h7FFF_FFFE, '0);

		// Fill the table: mostly ascending stamps, some mid-table inserts
		settle();
		write_offset($urandom_range(0, 2000) - 1000);
		send_item(OP_CLEAR, $urandom(), EIDX_W'($urandom()));
		first = $urandom_range(1000, 32'h4000_0000);
		t = first;
		while (sb.held < TABLE_DEPTH) begin
			r = $urandom_range(0, 39);
			if (r < 3) send_item(OP_QUERY, query_point(first, t - first), EIDX_W'($urandom()));
			else if (r < 5) send_item(OP_READ, $urandom(), EIDX_W'($urandom_range(0, sb.held)));
			else if (r == 5) send_item(OP_APPEND, $urandom_range(first, t), EIDX_W'($urandom()));
			else begin
				t = t + $urandom_range(0, 3);
				send_item(OP_APPEND, t, EIDX_W'($urandom()));
			end
		end
		repeat (3) send_item(OP_APPEND, $urandom(), EIDX_W'($urandom()));
		send_item(OP_READ, $urandom(), 10'h3FF);
		send_item(OP_QUERY, STAMP_MAX, EIDX_W'($urandom()));
		send_item(OP_QUERY, '0, EIDX_W'($urandom()));
		send_item(OP_READ, $urandom(), '0);

		// Random phases under several offsets
		run_mix(70, $urandom_range(0, 200) - 100);
		run_mix(70, 32'h8000_0000);
		run_mix(70, 32'h7FFF_FFFF);
		run_mix(70, $urandom());
		run_mix(70, '0);

		settle();
		repeat (100) @(posedge clk);
		if (sb.faults == 0 && sb.due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Check results; stall on a changing pattern, hold off twice for a long stretch
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tuser, m_axis_tdata);
			results_seen++;
			if (results_seen == 150 || results_seen == 1200) hold_left = 400;
		end
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 120);
		end
		mode_left--;
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (ready_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) != 0);
				2: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Stop the run when neither side moves a transaction for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

### files.f
rtl/scta_pkg.sv
rtl/scta_ram.sv
rtl/scta_bound.sv
rtl/sorted_cue_table_active_search_unit.sv
dv/sorted_cue_table_active_search_unit_tb.sv
